// ===== hdl/tcma_pkg.sv =====
package tcma_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_WINDOW      = 6;
    localparam int DEF_SAMPLE_BITS = 16;

    // Fixed field widths
    localparam int PERIOD_W  = 24;
    localparam int MEAN_W    = 24;
    localparam int STAMP_W   = 32;
    localparam int FRAC_BITS = 8;
    localparam int NUM_CH    = 3;

    // Configuration register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PUBLISH_PERIOD = 1'd1;

    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST  = 24'd1000;
    localparam logic [PERIOD_W-1:0] PUBLISH_PERIOD_RST = 24'd6000;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// ===== hdl/tcma_if.sv =====
// Tick channel: one transfer per millisecond tick with the three readings
interface tcma_in_if
    import tcma_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_sample;
    logic signed [SAMPLE_BITS-1:0] temp_sample;
    logic signed [SAMPLE_BITS-1:0] soil_sample;

    modport source (output valid, output accel_sample, output temp_sample,
                    output soil_sample, input ready);
    modport sink   (input valid, input accel_sample, input temp_sample,
                    input soil_sample, output ready);
endinterface

// Result channel: three window averages and the tick stamp
interface tcma_out_if
    import tcma_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [MEAN_W-1:0] accel_mean;
    logic signed [MEAN_W-1:0] temp_mean;
    logic signed [MEAN_W-1:0] soil_mean;
    logic [STAMP_W-1:0]       stamp;

    modport source (output valid, output accel_mean, output temp_mean,
                    output soil_mean, output stamp, input ready);
    modport sink   (input valid, input accel_mean, input temp_mean,
                    input soil_mean, input stamp, output ready);
endinterface

// ===== hdl/three_channel_moving_average_top.sv =====
// Three-channel sliding-window average.
// in_ch carries one transfer per millisecond tick with acceleration,
// temperature and soil readings. Every sample_period ticks the readings go
// into a WINDOW-deep ring memory and the running totals are updated; every
// publish_period ticks, once a sample is held, out_ch carries the three
// window averages (Q.8, truncated toward zero, saturated) and the tick stamp.
// cfg_wr_en/cfg_index/cfg_data write sample_period (index 0) and
// publish_period (index 1); write only while the block is idle.
// The bit-serial divider produces one quotient bit per cycle for all three
// channels together.
// The ring memory is read in the accept cycle and written back in the
// update cycle that follows; a result is loaded into the output register
// once the divide ends and that register is free.
// Reset sets the periods to 1000 and 6000, empties the window and clears
// the tick counter. A result waits in the output register while the
// receiver stalls; the next tick is still taken, and the block holds only
// when a second result is ready before the first has been transferred.
module three_channel_moving_average_top
    import tcma_pkg::*;
#(
    parameter int WINDOW      = DEF_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PERIOD_W-1:0]  cfg_data,
    tcma_in_if.sink              in_ch,
    tcma_out_if.source           out_ch
);

    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int TOTAL_W = SAMPLE_BITS + CNT_W;
    localparam int DIV_W   = TOTAL_W + FRAC_BITS;
    localparam int STEP_W  = $clog2(DIV_W + 1);
    localparam int SAT_W   = (DIV_W > MEAN_W + 1) ? DIV_W : MEAN_W + 1;

    localparam logic [CNT_W-1:0]  WIN_CNT   = CNT_W'(WINDOW);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic [SAT_W-1:0]  SAT_POS   = SAT_W'((2 ** (MEAN_W - 1)) - 1);
    localparam logic [SAT_W-1:0]  SAT_NEG   = SAT_W'(2 ** (MEAN_W - 1));
    localparam logic [MEAN_W-1:0] MEAN_MAX  = {1'b0, {(MEAN_W - 1){1'b1}}};
    localparam logic [MEAN_W-1:0] MEAN_MIN  = {1'b1, {(MEAN_W - 1){1'b0}}};

    // Control state
    state_t               state_reg;
    state_t               state_next;
    logic [PERIOD_W-1:0]  sample_period_reg;
    logic [PERIOD_W-1:0]  publish_period_reg;
    logic [STAMP_W-1:0]   tick_reg;
    logic [STAMP_W-1:0]   last_take_reg;
    logic [STAMP_W-1:0]   last_emit_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [CNT_W-1:0]     held_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 out_valid_reg;
    logic signed [TOTAL_W-1:0] total_reg [NUM_CH];

    // Payload
    logic [NUM_CH-1:0][SAMPLE_BITS-1:0] ring_mem [WINDOW];
    logic [NUM_CH-1:0][SAMPLE_BITS-1:0] ring_rd_reg;
    logic [NUM_CH-1:0][SAMPLE_BITS-1:0] sample_reg;
    logic [DIV_W-1:0]     quo_reg  [NUM_CH];
    logic [CNT_W-1:0]     rem_reg  [NUM_CH];
    logic                 neg_reg  [NUM_CH];
    logic [MEAN_W-1:0]    mean_reg [NUM_CH];
    logic [STAMP_W-1:0]   stamp_reg;

    // Combinational
    logic [STAMP_W-1:0]   now_next;
    logic                 take_hit;
    logic                 emit_hit;
    logic                 in_accept;
    logic                 out_load;
    logic signed [TOTAL_W-1:0] total_next [NUM_CH];
    logic [TOTAL_W-1:0]   mag_next   [NUM_CH];
    logic [CNT_W:0]       trial      [NUM_CH];
    logic [MEAN_W-1:0]    mean_next  [NUM_CH];
    logic [SAT_W-1:0]     quo_ext    [NUM_CH];
    logic [SAT_W-1:0]     quo_neg    [NUM_CH];

    // Period checks, handshakes
    assign now_next  = tick_reg + 1'b1;
    assign take_hit  = (now_next - last_take_reg) >= {8'd0, sample_period_reg};
    assign emit_hit  = ((tick_reg - last_emit_reg) >= {8'd0, publish_period_reg})
                       && (held_reg != '0);
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_accept = in_ch.valid && in_ch.ready;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || out_ch.ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = take_hit ? ST_UPDATE : ST_CHECK;
                end
            end
            ST_UPDATE: state_next = ST_CHECK;
            ST_CHECK:  state_next = emit_hit ? ST_DIV : ST_IDLE;
            ST_DIV:
            begin
                if (step_reg == STEP_W'(1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Per-channel arithmetic: total update, magnitude, divide step, saturation
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            total_next[ch] = total_reg[ch] + TOTAL_W'($signed(sample_reg[ch]));
            if (held_reg == WIN_CNT)
            begin
                total_next[ch] = total_next[ch] - TOTAL_W'($signed(ring_rd_reg[ch]));
            end
            mag_next[ch] = total_reg[ch][TOTAL_W-1] ? (TOTAL_W'(0) - total_reg[ch])
                                                    : total_reg[ch];
            trial[ch]    = {rem_reg[ch], quo_reg[ch][DIV_W-1]};
            quo_ext[ch]  = SAT_W'(quo_reg[ch]);
            quo_neg[ch]  = SAT_W'(0) - quo_ext[ch];
            if (!neg_reg[ch])
            begin
                mean_next[ch] = (quo_ext[ch] > SAT_POS) ? MEAN_MAX : quo_ext[ch][MEAN_W-1:0];
            end
            else
            begin
                mean_next[ch] = (quo_ext[ch] > SAT_NEG) ? MEAN_MIN : quo_neg[ch][MEAN_W-1:0];
            end
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes; unknown index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg  <= SAMPLE_PERIOD_RST;
            publish_period_reg <= PUBLISH_PERIOD_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SAMPLE_PERIOD:  sample_period_reg  <= cfg_data;
                REG_PUBLISH_PERIOD: publish_period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Tick counter, window bookkeeping and running totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            last_take_reg <= '0;
            last_emit_reg <= '0;
            slot_reg      <= '0;
            held_reg      <= '0;
            step_reg      <= '0;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                total_reg[ch] <= '0;
            end
        end
        else
        begin
            if (in_accept)
            begin
                tick_reg <= now_next;
                if (take_hit)
                begin
                    last_take_reg <= now_next;
                end
            end
            if (state_reg == ST_UPDATE)
            begin
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    total_reg[ch] <= total_next[ch];
                end
                slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                if (held_reg != WIN_CNT)
                begin
                    held_reg <= held_reg + 1'b1;
                end
            end
            if ((state_reg == ST_CHECK) && emit_hit)
            begin
                last_emit_reg <= tick_reg;
                step_reg      <= STEP_W'(DIV_W);
            end
            else if (state_reg == ST_DIV)
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    // Ring memory: read at accept, write back in the update cycle
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ring_rd_reg <= ring_mem[slot_reg];
        end
        if (state_reg == ST_UPDATE)
        begin
            ring_mem[slot_reg] <= sample_reg;
        end
    end

    // Capture readings; load and advance the divider
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg[0] <= in_ch.accel_sample;
            sample_reg[1] <= in_ch.temp_sample;
            sample_reg[2] <= in_ch.soil_sample;
        end
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            if ((state_reg == ST_CHECK) && emit_hit)
            begin
                neg_reg[ch] <= total_reg[ch][TOTAL_W-1];
                quo_reg[ch] <= {mag_next[ch], {FRAC_BITS{1'b0}}};
                rem_reg[ch] <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                if (trial[ch] >= {1'b0, held_reg})
                begin
                    rem_reg[ch] <= CNT_W'(trial[ch] - {1'b0, held_reg});
                    quo_reg[ch] <= {quo_reg[ch][DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[ch] <= trial[ch][CNT_W-1:0];
                    quo_reg[ch] <= {quo_reg[ch][DIV_W-2:0], 1'b0};
                end
            end
        end
    end

    // Output register: hold the result until the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                mean_reg[ch] <= mean_next[ch];
            end
            stamp_reg <= tick_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.accel_mean = mean_reg[0];
    assign out_ch.temp_mean  = mean_reg[1];
    assign out_ch.soil_mean  = mean_reg[2];
    assign out_ch.stamp      = stamp_reg;

    // The sample count moves only in the update cycle
    a_held_moves_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg != $past(held_reg)) |-> $past(state_reg == ST_UPDATE))
        else $error("sample count changed outside the update cycle");

    // The divider never runs on an empty window
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (held_reg != '0))
        else $error("divide started with no samples held");

    // A loaded result carries the current tick and is presented
    a_result_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_ch.valid && (out_ch.stamp == tick_reg)))
        else $error("result stamp does not match the tick counter");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    import tcma_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     WIN            = DEF_WINDOW;
    localparam int     SETTLE_CYCLES  = 64;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     RANDOM_TICKS   = 760;
    localparam longint MEAN_TOP       = (longint'(1) << (MEAN_W - 1)) - 1;
    localparam longint MEAN_BOTTOM    = -(longint'(1) << (MEAN_W - 1));

    typedef struct packed {
        logic signed [DEF_SAMPLE_BITS-1:0] accel;
        logic signed [DEF_SAMPLE_BITS-1:0] temp;
        logic signed [DEF_SAMPLE_BITS-1:0] soil;
    } tick_t;

    typedef struct packed {
        logic signed [MEAN_W-1:0] accel;
        logic signed [MEAN_W-1:0] temp;
        logic signed [MEAN_W-1:0] soil;
        logic [STAMP_W-1:0]       stamp;
    } mean_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PERIOD_W-1:0]  cfg_data;

    tcma_in_if #(.SAMPLE_BITS(DEF_SAMPLE_BITS)) in_ch ();
    tcma_out_if                                 out_ch ();

    three_channel_moving_average_top #(
        .WINDOW      (DEF_WINDOW),
        .SAMPLE_BITS (DEF_SAMPLE_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Window tracker: own copy of the block's state and registers
    logic [31:0] sample_gap   = 32'(SAMPLE_PERIOD_RST);
    logic [31:0] publish_gap  = 32'(PUBLISH_PERIOD_RST);
    longint      window_ring [NUM_CH][WIN];
    longint      window_sum  [NUM_CH] = '{default: 0};
    int          ring_slot    = 0;
    int          ring_fill    = 0;
    logic [31:0] tick_count   = '0;
    logic [31:0] last_sample  = '0;
    logic [31:0] last_publish = '0;

    mean_t expected_means[$];

    int error_count     = 0;
    int ticks_sent      = 0;
    int means_seen      = 0;
    int period_settings = 0;
    bit in_idle_on      = 1'b1;
    bit out_idle_on     = 1'b1;
    int hold_asked      = 0;
    int hold_served     = 0;
    int hold_left       = 0;
    int gap_left        = 0;
    int out_handled     = 0;

    // Clock: 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic signed [MEAN_W-1:0] scaled_mean(input longint total,
                                                             input int held);
        longint q;
        q = (total * (longint'(1) << FRAC_BITS)) / longint'(held);
        if (q > MEAN_TOP)
            q = MEAN_TOP;
        if (q < MEAN_BOTTOM)
            q = MEAN_BOTTOM;
        return q[MEAN_W-1:0];
    endfunction

    // Advance the tracker by one tick; queue a mean set when one is due
    task automatic track_tick(input tick_t t);
        longint      fresh [NUM_CH];
        logic [31:0] since_sample;
        logic [31:0] since_publish;
        mean_t       m;
        fresh[0] = longint'(t.accel);
        fresh[1] = longint'(t.temp);
        fresh[2] = longint'(t.soil);
        tick_count   = tick_count + 32'd1;
        since_sample = tick_count - last_sample;
        if (since_sample >= sample_gap)
        begin
            last_sample = tick_count;
            for (int c = 0; c < NUM_CH; c++)
            begin
                if (ring_fill >= WIN)
                    window_sum[c] -= window_ring[c][ring_slot];
                window_ring[c][ring_slot] = fresh[c];
                window_sum[c] += fresh[c];
            end
            ring_slot = (ring_slot + 1) % WIN;
            if (ring_fill < WIN)
                ring_fill++;
        end
        // a sample taken on this tick already counts towards the mean
        since_publish = tick_count - last_publish;
        if (since_publish >= publish_gap && ring_fill > 0)
        begin
            last_publish = tick_count;
            m.accel = scaled_mean(window_sum[0], ring_fill);
            m.temp  = scaled_mean(window_sum[1], ring_fill);
            m.soil  = scaled_mean(window_sum[2], ring_fill);
            m.stamp = tick_count;
            expected_means.push_back(m);
        end
    endtask

    // Offer one tick after a random gap and hold it until the transfer
    task automatic send_tick(input tick_t t);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 9) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid        <= 1'b1;
        in_ch.accel_sample <= t.accel;
        in_ch.temp_sample  <= t.temp;
        in_ch.soil_sample  <= t.soil;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        track_tick(t);
        ticks_sent++;
    endtask

    // Drop valid, wait for every queued mean and let the divider finish
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [PERIOD_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == REG_SAMPLE_PERIOD)
            sample_gap = 32'(value);
        else if (idx == REG_PUBLISH_PERIOD)
            publish_gap = 32'(value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_periods(input logic [PERIOD_W-1:0] sp,
                               input logic [PERIOD_W-1:0] pp);
        settle();
        write_reg(REG_SAMPLE_PERIOD, sp);
        write_reg(REG_PUBLISH_PERIOD, pp);
        period_settings++;
    endtask

    function automatic tick_t make_tick(input int a, input int t, input int s);
        tick_t k;
        k.accel = a[DEF_SAMPLE_BITS-1:0];
        k.temp  = t[DEF_SAMPLE_BITS-1:0];
        k.soil  = s[DEF_SAMPLE_BITS-1:0];
        return k;
    endfunction

    // Mostly full-range readings, with the rails and values near zero mixed in
    function automatic logic signed [DEF_SAMPLE_BITS-1:0] rand_reading();
        logic [31:0] r;
        int          v;
        case ($urandom_range(0, 7))
            0: v = 32767;
            1: v = -32768;
            2: v = int'($urandom_range(0, 6)) - 3;
            default:
            begin
                r = $urandom();
                v = int'(r);
            end
        endcase
        return v[DEF_SAMPLE_BITS-1:0];
    endfunction

    function automatic logic [PERIOD_W-1:0] rand_period();
        case ($urandom_range(0, 15))
            0:       return '0;
            1, 2:    return 24'd1;
            3:       return '1;
            4, 5:    return PERIOD_W'($urandom_range(7, 25));
            default: return PERIOD_W'($urandom_range(2, 6));
        endcase
    endfunction

    task automatic check_field(input string name, input longint expv,
                               input longint actv);
        if (expv != actv)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
            error_count++;
        end
    endtask

    // Compare each mean transfer with the oldest queued mean set
    always @(posedge clk)
    begin
        mean_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            means_seen++;
            if (expected_means.size() == 0)
            begin
                $error("mean transfer with stamp %0d arrived with none queued",
                       out_ch.stamp);
                error_count++;
            end
            else
            begin
                want = expected_means.pop_front();
                check_field("accel_mean", want.accel, out_ch.accel_mean);
                check_field("temp_mean",  want.temp,  out_ch.temp_mean);
                check_field("soil_mean",  want.soil,  out_ch.soil_mean);
                check_field("stamp",      want.stamp, out_ch.stamp);
            end
        end
    end

    // Receiver: random gap after each transfer, long hold when asked
    always @(negedge clk)
    begin
        if (hold_asked != hold_served)
        begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (means_seen != out_handled)
        begin
            out_handled = means_seen;
            gap_left    = out_idle_on ? $urandom_range(0, 9) : 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // Watchdog: end the run when nothing transfers for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Reset values: no sample is due within a few ticks, so nothing comes out
    task automatic test_reset_defaults();
        send_tick(make_tick(32767, -32768, 0));
        send_tick(make_tick(-1, 1, 12345));
    endtask

    // Widest period: no sample is ever taken, so no mean is published
    task automatic test_no_samples();
        set_periods('1, 24'd1);
        send_tick(make_tick(100, 200, 300));
        send_tick(make_tick(-100, -200, -300));
        send_tick(make_tick(32767, 32767, 32767));
    endtask

    // Zero periods: sample and publish on every tick; fill the window at both rails
    task automatic test_zero_periods();
        set_periods('0, '0);
        repeat (WIN)
            send_tick(make_tick(32767, -32768, 32767));
        repeat (WIN)
            send_tick(make_tick(-32768, 32767, -1));
    endtask

    // Sample and publish on differing periods, odd values to test truncation
    task automatic test_same_tick_sample();
        set_periods(24'd2, 24'd3);
        send_tick(make_tick(-1, 1, -3));
        send_tick(make_tick(2, -5, 7));
        send_tick(make_tick(-7, 3, -2));
        send_tick(make_tick(1, -1, 0));
        send_tick(make_tick(-32768, 32767, -32767));
        send_tick(make_tick(5, -4, 3));
    endtask

    // Hold the receiver for a long stretch while ticks keep coming
    task automatic test_backpressure();
        set_periods(24'd1, 24'd1);
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        hold_asked++;
        repeat (40)
            send_tick(make_tick(rand_reading(), rand_reading(), rand_reading()));
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    // Random phases: new periods and idling mode, then random readings
    task automatic test_random_phases();
        int target;
        int count;
        target = ticks_sent + RANDOM_TICKS;
        while (ticks_sent < target)
        begin
            set_periods(rand_period(), rand_period());
            in_idle_on  = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            count = $urandom_range(30, 70);
            repeat (count)
                send_tick(make_tick(rand_reading(), rand_reading(), rand_reading()));
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = REG_SAMPLE_PERIOD;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.accel_sample = '0;
        in_ch.temp_sample  = '0;
        in_ch.soil_sample  = '0;
        out_ch.ready       = 1'b0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_no_samples();
        test_zero_periods();
        test_same_tick_sample();
        test_backpressure();
        test_random_phases();
        settle();

        $display("Sent %0d ticks over %0d period settings and checked %0d mean sets,",
                 ticks_sent, period_settings, means_seen);
        $display("including zero and widest periods and one long receiver hold.");
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
